>>> hdl/bav_pkg.sv
// ---------------------------------------------------------------------------
// bav_pkg: shared types and constants
// Register indexes, item kinds and the control struct for the grid memory.
// ---------------------------------------------------------------------------
package bav_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_SCALE_X  = 2'd2;
  localparam logic [1:0] CFG_SCALE_Y  = 2'd3;

  // Item kinds carried on tuser.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Low bits of the coordinate product that are ever used (cell up to 10 bits).
  localparam int unsigned PROD_W = 42;

  // Control from the pipeline to the grid memory.
  typedef struct packed {
    logic adv;  // pipeline moves on this edge
    logic wr;   // the item at the memory stage is a grid write
  } mem_ctl_t;

endpackage

>>> hdl/bav_locate.sv
// ---------------------------------------------------------------------------
// bav_locate: position to grid cell
// Forms (pos - origin) * scale over three stages and splits the Q32.32
// result into a wrapped cell index and a 16-bit fraction.
// ---------------------------------------------------------------------------
module bav_locate #(
  parameter int unsigned CELL_W = 7
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       pos_i,
  input  logic [31:0]       org_i,
  input  logic [31:0]       scale_i,
  output logic [CELL_W-1:0] cell_o,
  output logic [15:0]       frac_o
);

  localparam int unsigned SPLIT = bav_pkg::PROD_W / 2;

  logic [32:0]               diff_d, diff_q;
  logic [bav_pkg::PROD_W-1:0] dext;
  logic [SPLIT+31:0]         pp_lo_d, pp_lo_q, pp_hi_d;
  logic [SPLIT-1:0]          pp_hi_q;
  logic [bav_pkg::PROD_W-1:0] prod_d, prod_q;

  // Offset from the field origin at 33 bits.
  assign diff_d = {pos_i[31], pos_i} - {org_i[31], org_i};

  // Two partial products, each 21 by 32 bits; only the low 42 bits matter.
  always_comb begin
    dext    = {{(bav_pkg::PROD_W-33){diff_q[32]}}, diff_q};
    pp_lo_d = dext[SPLIT-1:0] * scale_i;
    pp_hi_d = dext[bav_pkg::PROD_W-1:SPLIT] * scale_i;
    prod_d  = pp_lo_q[bav_pkg::PROD_W-1:0] + {pp_hi_q, {SPLIT{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d[SPLIT-1:0];
      prod_q  <= prod_d;
    end
  end

  // Cell from the integer part, wrapped by the power-of-two side.
  assign cell_o = prod_q[32 +: CELL_W];
  assign frac_o = prod_q[31:16];

endmodule

>>> hdl/bav_mem.sv
// ---------------------------------------------------------------------------
// bav_mem: banked flow grid
// Four banks split by column and row parity, so the four corners of a cell
// are read in the same cycle. Writes go to one bank at the same stage.
// ---------------------------------------------------------------------------
module bav_mem #(
  parameter int unsigned COL_W = 7,
  parameter int unsigned ROW_W = 7
) (
  input  logic              clk_i,
  input  bav_pkg::mem_ctl_t ctl_i,
  input  logic [COL_W-1:0]  wr_col_i,
  input  logic [ROW_W-1:0]  wr_row_i,
  input  logic [31:0]       wr_data_i,
  input  logic [COL_W-1:0]  rd_col_i,
  input  logic [ROW_W-1:0]  rd_row_i,
  output logic [31:0]       corner_a_o,
  output logic [31:0]       corner_b_o,
  output logic [31:0]       corner_c_o,
  output logic [31:0]       corner_d_o
);

  localparam int unsigned DEPTH = 2 ** (COL_W + ROW_W - 2);
  localparam int unsigned AW    = (COL_W + ROW_W > 2) ? (COL_W + ROW_W - 2) : 1;
  localparam int unsigned HALF_W = 2 ** (COL_W - 1);

  function automatic logic [AW-1:0] bank_addr(input logic [COL_W-1:0] col,
                                               input logic [ROW_W-1:0] row);
    logic [31:0] a;
    a = (32'(row) >> 1) * 32'(HALF_W) + (32'(col) >> 1);
    return a[AW-1:0];
  endfunction

  logic [31:0]   rdata_q [4];
  logic [1:0]    par_q;
  logic [1:0]    wsel;
  logic [AW-1:0] waddr;

  assign wsel  = {wr_row_i[0], wr_col_i[0]};
  assign waddr = bank_addr(wr_col_i, wr_row_i);

  // One bank per parity pair; the +1 neighbour wraps with the index width.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = logic'(b % 2);
    localparam logic RP = logic'(b / 2);
    logic [31:0]      mem_q [DEPTH];
    logic [COL_W-1:0] rcol;
    logic [ROW_W-1:0] rrow;
    logic [AW-1:0]    raddr;

    always_comb begin
      rcol  = (rd_col_i[0] == CP) ? rd_col_i : COL_W'(rd_col_i + 1'b1);
      rrow  = (rd_row_i[0] == RP) ? rd_row_i : ROW_W'(rd_row_i + 1'b1);
      raddr = bank_addr(rcol, rrow);
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv && ctl_i.wr && (wsel == 2'(b))) begin
        mem_q[waddr] <= wr_data_i;
      end
      if (ctl_i.adv) begin
        rdata_q[b] <= mem_q[raddr];
      end
    end
  end

  // Parity of the base cell decides which bank holds which corner.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      par_q <= {rd_row_i[0], rd_col_i[0]};
    end
  end

  always_comb begin
    unique case (par_q)
      2'b00: begin
        corner_a_o = rdata_q[0]; corner_b_o = rdata_q[1];
        corner_c_o = rdata_q[2]; corner_d_o = rdata_q[3];
      end
      2'b01: begin
        corner_a_o = rdata_q[1]; corner_b_o = rdata_q[0];
        corner_c_o = rdata_q[3]; corner_d_o = rdata_q[2];
      end
      2'b10: begin
        corner_a_o = rdata_q[2]; corner_b_o = rdata_q[3];
        corner_c_o = rdata_q[0]; corner_d_o = rdata_q[1];
      end
      default: begin
        corner_a_o = rdata_q[3]; corner_b_o = rdata_q[2];
        corner_c_o = rdata_q[1]; corner_d_o = rdata_q[0];
      end
    endcase
  end

endmodule

>>> hdl/bav_blend.sv
// ---------------------------------------------------------------------------
// bav_blend: bilinear blend of one vector component
// Three stages: both horizontal lerps, the vertical lerp, then rounding to
// Q1.14 with saturation.
// ---------------------------------------------------------------------------
module bav_blend (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  input  logic [15:0] c_i,
  input  logic [15:0] d_i,
  input  logic [15:0] fx_i,
  input  logic [15:0] fy_i,
  output logic [15:0] sample_o
);

  logic signed [16:0] d_ab, d_cd, fx_s, fy_s;
  logic signed [33:0] m_lo, m_hi, lo_d, hi_d, lo_q, hi_q;
  logic [15:0]        fy_q;
  logic signed [34:0] d_hl;
  logic signed [51:0] m_v, v_d, v_q, t;
  logic signed [19:0] r;
  logic [15:0]        sample_d;

  // Horizontal lerps as a*2^16 + (b-a)*fx, one multiplier each.
  always_comb begin
    fx_s = $signed({1'b0, fx_i});
    d_ab = $signed({b_i[15], b_i}) - $signed({a_i[15], a_i});
    d_cd = $signed({d_i[15], d_i}) - $signed({c_i[15], c_i});
    m_lo = d_ab * fx_s;
    m_hi = d_cd * fx_s;
    lo_d = m_lo + $signed({{2{a_i[15]}}, a_i, 16'h0000});
    hi_d = m_hi + $signed({{2{c_i[15]}}, c_i, 16'h0000});
  end

  // Vertical lerp at scale 2^32.
  always_comb begin
    fy_s = $signed({1'b0, fy_q});
    d_hl = $signed({hi_q[33], hi_q}) - $signed({lo_q[33], lo_q});
    m_v  = d_hl * fy_s;
    v_d  = m_v + $signed({{2{lo_q[33]}}, lo_q, 16'h0000});
  end

  // Round half up to Q1.14 and saturate to 16 bits.
  always_comb begin
    t = v_q + 52'sd2147483648;
    r = t[51:32];
    if (r > 20'sd32767) begin
      sample_d = 16'h7FFF;
    end else if (r < -20'sd32768) begin
      sample_d = 16'h8000;
    end else begin
      sample_d = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      fy_q     <= fy_i;
      v_q      <= v_d;
      sample_o <= sample_d;
    end
  end

endmodule

>>> hdl/vector_field_bilinear_advect_top.sv
// ---------------------------------------------------------------------------
// vector_field_bilinear_advect_top: bilinear flow sampler with Euler step
// Holds a grid of Q1.14 flow vectors and answers position queries with the
// interpolated vector and the advected position.
// ---------------------------------------------------------------------------
// Use: input beats arrive on s_axis; tuser selects a grid write (0) or a
// query (1). A write stores one vector and gives no output beat. A query
// gives one beat on m_axis with the sample and the next position.
// Configuration (origin and cells per unit in x and y) is written through
// cfg_we_i/cfg_addr_i/cfg_wdata_i while no beat is in flight.
// Throughput: one beat per cycle while m_axis is not stalled, writes and
// queries freely mixed; the four corners come from four parity banks read
// in the same cycle. A query beat passes through the coordinate multiply,
// bank read, three blend stages, step multiply, and add and saturate before
// it is presented on m_axis.
// Writes and reads meet the grid at the same pipeline stage, so a query
// always sees every write accepted before it.
// Reset clears the stage valids, zeroes the origins and sets the scales to
// 1.0; the grid stays unknown until written. On an m_axis stall the whole
// pipeline and the output beat hold; s_axis tready drops in the same cycle.
// ---------------------------------------------------------------------------
module vector_field_bilinear_advect_top #(
  parameter int unsigned GRID_WIDTH  = 128,
  parameter int unsigned GRID_HEIGHT = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_col[6:0], cell_row[13:7], load_vx[29:14], load_vy[45:30],
  // pos_x[77:46], pos_y[109:78], step_size[141:110], use_complement[142]
  input  logic [143:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sample_x[15:0], sample_y[31:16], next_x[63:32], next_y[95:64]
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned COL_W = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W = $clog2(GRID_HEIGHT);

  // Configuration registers.
  logic [31:0] org_x_q, org_y_q, scale_x_q, scale_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      scale_x_q <= 32'h0001_0000;
      scale_y_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bav_pkg::CFG_ORIGIN_X: org_x_q   <= cfg_wdata_i;
        bav_pkg::CFG_ORIGIN_Y: org_y_q   <= cfg_wdata_i;
        bav_pkg::CFG_SCALE_X:  scale_x_q <= cfg_wdata_i;
        default:               scale_y_q <= cfg_wdata_i;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the output beat is stuck.
  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage valids and item context.
  logic [8:1]       vld_q, qry_q;
  logic [7:1]       comp_q;
  logic [31:0]      pos_x_q [1:8];
  logic [31:0]      pos_y_q [1:8];
  logic [31:0]      step_q  [1:7];
  logic [COL_W-1:0] wcol_q  [1:3];
  logic [ROW_W-1:0] wrow_q  [1:3];
  logic [31:0]      wdat_q  [1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[7:1], s_axis_tvalid};
      out_vld_q <= vld_q[8] && qry_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qry_q      <= {qry_q[7:1], s_axis_tuser == bav_pkg::ACT_QUERY};
      comp_q     <= {comp_q[6:1], s_axis_tdata[142]};
      pos_x_q[1] <= s_axis_tdata[77:46];
      pos_y_q[1] <= s_axis_tdata[109:78];
      step_q[1]  <= s_axis_tdata[141:110];
      wcol_q[1]  <= COL_W'(32'(s_axis_tdata[6:0]));
      wrow_q[1]  <= ROW_W'(32'(s_axis_tdata[13:7]));
      wdat_q[1]  <= {s_axis_tdata[45:30], s_axis_tdata[29:14]};
      for (int k = 2; k <= 8; k++) begin
        pos_x_q[k] <= pos_x_q[k-1];
        pos_y_q[k] <= pos_y_q[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
        step_q[k] <= step_q[k-1];
      end
      for (int k = 2; k <= 3; k++) begin
        wcol_q[k] <= wcol_q[k-1];
        wrow_q[k] <= wrow_q[k-1];
        wdat_q[k] <= wdat_q[k-1];
      end
    end
  end

  // Grid coordinates, ready at stage 3.
  logic [COL_W-1:0] cell_x;
  logic [ROW_W-1:0] cell_y;
  logic [15:0]      frac_x, frac_y, fx_q, fy_q;

  bav_locate #(.CELL_W(COL_W)) u_loc_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .pos_i   (s_axis_tdata[77:46]),
    .org_i   (org_x_q),
    .scale_i (scale_x_q),
    .cell_o  (cell_x),
    .frac_o  (frac_x)
  );

  bav_locate #(.CELL_W(ROW_W)) u_loc_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .pos_i   (s_axis_tdata[109:78]),
    .org_i   (org_y_q),
    .scale_i (scale_y_q),
    .cell_o  (cell_y),
    .frac_o  (frac_y)
  );

  // Fractions are registered beside the bank read, so both reach the blend together.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q <= frac_x;
      fy_q <= frac_y;
    end
  end

  // Grid memory: a write or a four-corner read for the item at stage 3.
  bav_pkg::mem_ctl_t mem_ctl;
  logic [31:0]       cor_a, cor_b, cor_c, cor_d;

  always_comb begin
    mem_ctl.adv = adv;
    mem_ctl.wr  = vld_q[3] && !qry_q[3];
  end

  bav_mem #(.COL_W(COL_W), .ROW_W(ROW_W)) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .wr_col_i   (wcol_q[3]),
    .wr_row_i   (wrow_q[3]),
    .wr_data_i  (wdat_q[3]),
    .rd_col_i   (cell_x),
    .rd_row_i   (cell_y),
    .corner_a_o (cor_a),
    .corner_b_o (cor_b),
    .corner_c_o (cor_c),
    .corner_d_o (cor_d)
  );

  // Bilinear blend per component, result at stage 7.
  logic [15:0] smp_x, smp_y;

  bav_blend u_blend_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .a_i      (cor_a[15:0]),
    .b_i      (cor_b[15:0]),
    .c_i      (cor_c[15:0]),
    .d_i      (cor_d[15:0]),
    .fx_i     (fx_q),
    .fy_i     (fy_q),
    .sample_o (smp_x)
  );

  bav_blend u_blend_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .a_i      (cor_a[31:16]),
    .b_i      (cor_b[31:16]),
    .c_i      (cor_c[31:16]),
    .d_i      (cor_d[31:16]),
    .fx_i     (fx_q),
    .fy_i     (fy_q),
    .sample_o (smp_y)
  );

  // Optional left rotation and the step products.
  logic [15:0]        sx_c, sy_c, neg_y, sx_q, sy_q;
  logic signed [47:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;

  always_comb begin
    neg_y = (smp_y == 16'h8000) ? 16'h7FFF : 16'(-smp_y);
    sx_c  = comp_q[7] ? neg_y : smp_x;
    sy_c  = comp_q[7] ? smp_x : smp_y;
    prod_x_d = $signed(step_q[7]) * $signed(sx_c);
    prod_y_d = $signed(step_q[7]) * $signed(sy_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q     <= sx_c;
      sy_q     <= sy_c;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
  end

  // Round the displacement to Q16.16, add and saturate.
  logic signed [47:0] rnd_x, rnd_y;
  logic signed [34:0] sum_x, sum_y;
  logic [31:0]        nx_d, ny_d, nx_q, ny_q;
  logic [15:0]        osx_q, osy_q;

  always_comb begin
    rnd_x = prod_x_q + 48'sd8192;
    rnd_y = prod_y_q + 48'sd8192;
    sum_x = $signed({{3{pos_x_q[8][31]}}, pos_x_q[8]}) + $signed({rnd_x[47], rnd_x[47:14]});
    sum_y = $signed({{3{pos_y_q[8][31]}}, pos_y_q[8]}) + $signed({rnd_y[47], rnd_y[47:14]});
    if (sum_x > 35'sd2147483647) begin
      nx_d = 32'h7FFF_FFFF;
    end else if (sum_x < -35'sd2147483648) begin
      nx_d = 32'h8000_0000;
    end else begin
      nx_d = sum_x[31:0];
    end
    if (sum_y > 35'sd2147483647) begin
      ny_d = 32'h7FFF_FFFF;
    end else if (sum_y < -35'sd2147483648) begin
      ny_d = 32'h8000_0000;
    end else begin
      ny_d = sum_y[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      osx_q <= sx_q;
      osy_q <= sy_q;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {ny_q, nx_q, osy_q, osx_q};

`ifndef NO_ASSERTIONS
  // A stall freezes every stage; checked here on the stage valids.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  // A query leaving the last stage always becomes an output beat.
  a_query_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[8] && qry_q[8] |=> out_vld_q)
    else $error("query lost at the output register");

  // An output beat only appears from a query.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(vld_q[8] && qry_q[8]))
    else $error("output beat without a query");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: checks the bilinear flow sampler with Euler advection
// Loads grid vectors, sends position queries under several origin and scale
// settings and compares every output beat with a predictor kept in step.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned GW = 128;
  localparam int unsigned GH = 128;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        use_complement;
    logic [31:0] step_size;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] load_vy;
    logic [15:0] load_vx;
    logic [6:0]  cell_row;
    logic [6:0]  cell_col;
  } flow_item_t;

  typedef struct packed {
    logic [31:0] next_y;
    logic [31:0] next_x;
    logic [15:0] sample_y;
    logic [15:0] sample_x;
  } flow_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  // Predictor state: grid copy, written flags and the four registers.
  logic [31:0]     grid_model [GW*GH];
  bit              grid_written [GW*GH];
  logic signed [63:0] org_x, org_y;
  logic [63:0]     scale_x, scale_y;

  flow_result_t expected_results [$];
  int unsigned  error_count = 0;
  int unsigned  result_count = 0;
  int unsigned  query_count = 0;
  longint unsigned cycle_count = 0;
  bit           hold_off = 1'b0;
  int unsigned  hold_cycles = 0;
  bit           stall_random = 1'b1;

  vector_field_bilinear_advect_top #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Saturate a signed value to w bits.
  function automatic logic signed [63:0] clamp(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic signed [63:0] blend_corners(logic signed [63:0] a,
      logic signed [63:0] b, logic signed [63:0] c, logic signed [63:0] d,
      logic signed [63:0] fx, logic signed [63:0] fy);
    logic signed [63:0] lo, hi, v;
    lo = a * (65536 - fx) + b * fx;
    hi = c * (65536 - fx) + d * fx;
    v = lo * (65536 - fy) + hi * fy;
    return clamp((v + (64'sd1 <<< 31)) >>> 32, 16);
  endfunction

  function automatic flow_result_t sample_and_advect(flow_item_t it);
    logic signed [63:0] px, py, stp, fx, fy, sx, sy, t;
    logic signed [63:0] ex [4];
    logic signed [63:0] ey [4];
    logic [63:0] prod_x, prod_y;
    int unsigned cx, cy, idx;
    flow_result_t r;
    px = $signed(it.pos_x);
    py = $signed(it.pos_y);
    stp = $signed(it.step_size);
    prod_x = 64'(px - org_x) * scale_x;
    prod_y = 64'(py - org_y) * scale_y;
    fx = 64'(prod_x[31:16]);
    fy = 64'(prod_y[31:16]);
    cx = prod_x[63:32];
    cy = prod_y[63:32];
    for (int k = 0; k < 4; k++) begin
      idx = ((cx + k % 2) % GW) + GW * ((cy + k / 2) % GH);
      ex[k] = $signed(grid_model[idx][15:0]);
      ey[k] = $signed(grid_model[idx][31:16]);
    end
    sx = blend_corners(ex[0], ex[1], ex[2], ex[3], fx, fy);
    sy = blend_corners(ey[0], ey[1], ey[2], ey[3], fx, fy);
    if (it.use_complement) begin
      t = sx;
      sx = clamp(-sy, 16);
      sy = t;
    end
    r.sample_x = sx[15:0];
    r.sample_y = sy[15:0];
    r.next_x = 32'(clamp(px + ((stp * sx + (64'sd1 <<< 13)) >>> 14), 32));
    r.next_y = 32'(clamp(py + ((stp * sy + (64'sd1 <<< 13)) >>> 14), 32));
    return r;
  endfunction

  // True when all four corners of the cell that a position maps to are loaded.
  function automatic bit corners_written(logic [31:0] px, logic [31:0] py);
    logic [63:0] prod_x, prod_y;
    int unsigned cx, cy, idx;
    bit ok;
    prod_x = 64'($signed(px) - org_x) * scale_x;
    prod_y = 64'($signed(py) - org_y) * scale_y;
    cx = prod_x[63:32];
    cy = prod_y[63:32];
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx = ((cx + k % 2) % GW) + GW * ((cy + k / 2) % GH);
      ok = ok && grid_written[idx];
    end
    return ok;
  endfunction

  // Receiver stall pattern; a long hold-off is counted here.
  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      if (hold_cycles == 0) hold_off <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (stall_random) begin
      m_axis_tready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    flow_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.sample_x !== want.sample_x) begin
          $display("%0t: sample_x expected %h actual %h", $realtime, want.sample_x, got.sample_x);
          error_count++;
        end
        if (got.sample_y !== want.sample_y) begin
          $display("%0t: sample_y expected %h actual %h", $realtime, want.sample_y, got.sample_y);
          error_count++;
        end
        if (got.next_x !== want.next_x) begin
          $display("%0t: next_x expected %h actual %h", $realtime, want.next_x, got.next_x);
          error_count++;
        end
        if (got.next_y !== want.next_y) begin
          $display("%0t: next_y expected %h actual %h", $realtime, want.next_y, got.next_y);
          error_count++;
        end
      end
    end
  end

  // Offer one beat, wait for acceptance and update the predictor. Valid stays
  // high afterwards so that beats can follow back to back.
  task automatic send_item(logic act, flow_item_t it);
    int unsigned idx;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {1'b0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == bav_pkg::ACT_WRITE) begin
      idx = it.cell_col + GW * it.cell_row;
      grid_model[idx] = {it.load_vy, it.load_vx};
      grid_written[idx] = 1'b1;
    end else begin
      expected_results.push_back(sample_and_advect(it));
      query_count++;
    end
    @(negedge clk_i);
  endtask

  // Drop valid for a number of cycles.
  task automatic idle(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_vector(int col, int row, logic [15:0] vx, logic [15:0] vy);
    flow_item_t it;
    it = flow_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.cell_col = 7'(col);
    it.cell_row = 7'(row);
    it.load_vx = vx;
    it.load_vy = vy;
    send_item(bav_pkg::ACT_WRITE, it);
  endtask

  task automatic query(logic [31:0] px, logic [31:0] py, logic [31:0] stp, logic comp);
    flow_item_t it;
    it = flow_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.pos_x = px;
    it.pos_y = py;
    it.step_size = stp;
    it.use_complement = comp;
    send_item(bav_pkg::ACT_QUERY, it);
  endtask

  // Random query over loaded cells only; the origin itself is the fallback,
  // since it always lands on cell zero.
  task automatic random_query();
    logic [31:0] px, py;
    bit found;
    found = 1'b0;
    px = '0;
    py = '0;
    for (int tries = 0; tries < 4000 && !found; tries++) begin
      px = $urandom;
      py = $urandom;
      found = corners_written(px, py);
    end
    if (!found) begin
      px = org_x[31:0];
      py = org_y[31:0];
    end
    query(px, py, ($urandom_range(0, 1) ? $urandom : $urandom >>> 12),
          1'($urandom_range(0, 1)));
  endtask

  // Wait for the pipeline to drain, then a few cycles more.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // One register write per cycle; the enable stays high across a sequence.
  task automatic write_register(logic [1:0] addr, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    case (addr)
      bav_pkg::CFG_ORIGIN_X: org_x = $signed(value);
      bav_pkg::CFG_ORIGIN_Y: org_y = $signed(value);
      bav_pkg::CFG_SCALE_X:  scale_x = 64'(value);
      default:               scale_y = 64'(value);
    endcase
  endtask

  // Write all four registers with the pipeline empty.
  task automatic write_config(logic [31:0] ox, logic [31:0] oy,
                              logic [31:0] kx, logic [31:0] ky);
    write_register(bav_pkg::CFG_ORIGIN_X, ox);
    write_register(bav_pkg::CFG_ORIGIN_Y, oy);
    write_register(bav_pkg::CFG_SCALE_X, kx);
    write_register(bav_pkg::CFG_SCALE_Y, ky);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Load the cells near each corner of the grid, wrap neighbours included.
  task automatic test_fill_grid();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        write_vector((c < 8) ? c : c + GW - 16, (r < 8) ? r : r + GH - 16,
                     16'($urandom), 16'($urandom));
  endtask

  // Extremes of vectors, positions, steps, wrapping and the complement case.
  task automatic test_directed();
    write_vector(0, 0, 16'h8000, 16'h8000);
    write_vector(1, 0, 16'h7fff, 16'h7fff);
    write_vector(0, 1, 16'h8000, 16'h7fff);
    write_vector(1, 1, 16'h7fff, 16'h8000);
    write_vector(GW - 1, GH - 1, 16'h8000, 16'h8000);
    query(32'h0, 32'h0, 32'h0001_0000, 1'b0);
    query(32'h0, 32'h0, 32'h7fff_ffff, 1'b1);
    query(32'h0000_8000, 32'h0000_8000, 32'h8000_0000, 1'b0);
    query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    query(32'hffff_ffff, 32'hffff_0000, 32'h0000_0001, 1'b0);
    query(32'h007f_8000, 32'h007f_c000, 32'h0002_0000, 1'b1);
    query(32'h0000_0000, 32'h007f_0000, 32'hffff_0000, 1'b0);
    drain();
    write_config(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
    query(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b0);
    query(32'h1234_567d, 32'h0, 32'h8000_0000, 1'b1);
    drain();
  endtask

  // Random bursts of mixed writes and queries under one register setting.
  task automatic test_random_phase(int n, logic [31:0] ox, logic [31:0] oy,
                                   logic [31:0] kx, logic [31:0] ky);
    int burst;
    drain();
    write_config(ox, oy, kx, ky);
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        if ($urandom_range(0, 3) == 0)
          write_vector($urandom_range(0, 127), $urandom_range(0, 127),
                       16'($urandom), 16'($urandom));
        else
          random_query();
      end
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
    end
  endtask

  // Long receiver hold-off while the sender keeps offering queries.
  task automatic test_backpressure();
    hold_cycles = 60;
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) random_query();
    drain();
  endtask

  initial begin
    org_x = 0;
    org_y = 0;
    scale_x = 64'd65536;
    scale_y = 64'd65536;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_fill_grid();
    test_directed();
    test_random_phase(180, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    test_random_phase(180, $urandom, $urandom, $urandom, $urandom);
    test_backpressure();
    stall_random = 1'b0;
    test_random_phase(180, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    stall_random = 1'b1;
    test_random_phase(180, 32'hffff_0000, 32'h0001_0000, 32'h0080_0000, 32'h0000_4000);
    drain();
    $display("Run covered %0d queries and %0d output beats over loaded corner regions,",
             query_count, result_count);
    $display("several register settings, random idling and one long output stall.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
